>>> hw/rtl/tes_pkg.sv
// Shared types, constants and helpers for the thermal erosion stencil.
// Depends on nothing; every other file of the block depends on it.
`default_nettype none

package tes_pkg;

   localparam int DEF_MAX_ROW_LENGTH = 1024;
   localparam int MAX_ROW_COUNT      = 4096;

   localparam int HEIGHT_W   = 16;
   localparam int ROW_LEN_W  = 11;
   localparam int ROW_CNT_W  = 13;
   localparam int OUT_ROW_W  = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RESET = 11'd1024;
   localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RESET  = 13'd1024;

   // erosion arithmetic
   localparam int SUM_W       = 19;                 // 8 excesses of 16 bits
   localparam int CNT_W       = 4;                  // 0..8 low neighbors
   localparam int PROD_W      = SUM_W + HEIGHT_W;
   localparam int FRAC_SHIFT  = 18;                 // /4 and the Q0.16 gain
   localparam int QUOT_W      = PROD_W - FRAC_SHIFT;
   localparam int REM_W       = 4;
   localparam int SCAN_IDX_W  = 3;
   localparam int DIV_CNT_W   = 5;
   localparam logic [SCAN_IDX_W-1:0] SCAN_LAST = 3'd7;
   localparam logic [DIV_CNT_W-1:0]  DIV_LAST  = 5'(QUOT_W - 1);

   localparam int WIN_SIZE   = 9;
   localparam int WIN_IDX_W  = 4;
   localparam logic [WIN_IDX_W-1:0] WIN_CENTRE = 4'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_LENGTH  = 2'd0,
      CSR_ROW_COUNT   = 2'd1,
      CSR_TALUS_LIMIT = 2'd2,
      CSR_MOVE_GAIN   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_MULT,
      ST_DIVIDE,
      ST_FIX,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic ready;    // input side may take a word
      logic accept;   // input word taken this cycle
      logic load;     // shift window, write line stores, advance counters
      logic scan;     // fold one neighbor into sum and count
      logic mult;     // sum times gain
      logic div;      // one quotient bit
      logic fix;      // subtract the moved amount from the centre
      logic emit;     // load the output register
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic drop;       // drain tick before the map is complete
      logic emit;       // this word produces a result
      logic interior;   // result cell needs erosion
      logic scan_last;
      logic count_zero;
      logic div_last;
      logic out_free;
   } status_type;

   // Window slot of neighbor k, rows oldest first, centre skipped.
   function automatic logic [WIN_IDX_W-1:0] nb_index(input logic [SCAN_IDX_W-1:0] k);
      logic [WIN_IDX_W-1:0] idx;
      idx = {1'b0, k};
      if (k >= 3'd4) begin
         idx = {1'b0, k} + 4'd1;
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tes_req_if.sv
// Input channel of the erosion stencil: one height sample or drain tick per word.
// Depends on tes_pkg for field widths.
`default_nettype none

interface tes_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [tes_pkg::HEIGHT_W-1:0]  height_in;

   modport source (output valid, req_type, height_in, input ready);
   modport sink   (input valid, req_type, height_in, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tes_rsp_if.sv
// Result channel of the erosion stencil: one output height per word.
// Depends on tes_pkg for field widths.
`default_nettype none

interface tes_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tes_pkg::HEIGHT_W-1:0]  height_out;
   logic                          map_end;

   modport source (output valid, height_out, map_end, input ready);
   modport sink   (input valid, height_out, map_end, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tes_csr_if.sv
// Register write channel of the erosion stencil.
// Depends on tes_pkg for index and data widths.
`default_nettype none

interface tes_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tes_pkg::CSR_IDX_W-1:0]   index;
   logic [tes_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tes_ctrl.sv
// Sequencer of the erosion stencil: steps one word through load, scan, multiply, divide, fix, emit.
// Depends on tes_pkg for state, command and status types.
`default_nettype none

module tes_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire tes_pkg::status_type  status,
   output tes_pkg::cmd_type          cmd
);
   import tes_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.req_valid && !status.drop) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.interior) begin
               state_in = ST_SCAN;
            end else if (status.emit) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            // no low neighbor: the centre already sits in the result register
            state_in = status.count_zero ? ST_EMIT : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.ready  = 1'b1;
            cmd.accept = status.req_valid;
         end
         ST_LOAD:   cmd.load = 1'b1;
         ST_SCAN:   cmd.scan = 1'b1;
         ST_MULT:   cmd.mult = 1'b1;
         ST_DIVIDE: cmd.div  = 1'b1;
         ST_FIX:    cmd.fix  = 1'b1;
         ST_EMIT:   cmd.emit = status.out_free;
         default:   cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/tes_dpath.sv
// Datapath of the erosion stencil: registers, line stores, 3x3 window, stream
// counters, neighbor scan, multiplier, restoring divider and output register.
// Depends on tes_pkg and the three channel interfaces.
`default_nettype none

module tes_dpath #(
   parameter int MAX_ROW_LENGTH = tes_pkg::DEF_MAX_ROW_LENGTH
) (
   input  wire                  clock,
   input  wire                  reset,
   tes_req_if.sink              req_ch,
   tes_rsp_if.source            rsp_ch,
   tes_csr_if.sink              csr_ch,
   input  wire tes_pkg::cmd_type cmd,
   output tes_pkg::status_type  status
);
   import tes_pkg::*;

   localparam int COL_W = $clog2(MAX_ROW_LENGTH);
   localparam int WID_W = $clog2(MAX_ROW_LENGTH + 1);

   // registers
   logic [ROW_LEN_W-1:0]  row_length_ff;
   logic [ROW_CNT_W-1:0]  row_count_ff;
   logic [HEIGHT_W-1:0]   talus_ff;
   logic [HEIGHT_W-1:0]   gain_ff;

   // stream position
   logic [COL_W-1:0]      col_ff;
   logic [ROW_CNT_W-1:0]  row_ff;
   logic [COL_W-1:0]      ox_ff;
   logic [OUT_ROW_W-1:0]  oz_ff;

   logic [HEIGHT_W-1:0]   store_a_ff [MAX_ROW_LENGTH];
   logic [HEIGHT_W-1:0]   store_b_ff [MAX_ROW_LENGTH];
   logic [HEIGHT_W-1:0]   rd_a_ff;
   logic [HEIGHT_W-1:0]   rd_b_ff;
   logic [HEIGHT_W-1:0]   win_ff [WIN_SIZE];
   logic [HEIGHT_W-1:0]   sample_ff;

   logic [SCAN_IDX_W-1:0] scan_idx_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic [QUOT_W-1:0]     dq_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [HEIGHT_W-1:0]   result_ff;
   logic                  last_ff;
   logic                  interior_ff;

   logic                  rsp_valid_ff;
   logic [HEIGHT_W-1:0]   rsp_height_ff;
   logic                  rsp_end_ff;

   logic [WID_W-1:0]      eff_w;
   logic [ROW_CNT_W-1:0]  eff_h;
   logic                  data_phase;
   logic                  emit_now;
   logic                  col_end;
   logic                  ox_end;
   logic                  oz_end;
   logic                  last_now;
   logic                  interior_now;
   logic                  csr_take;
   logic                  geom_write;

   logic [HEIGHT_W-1:0]   centre;
   logic [HEIGHT_W-1:0]   nb;
   logic [HEIGHT_W-1:0]   diff;
   logic                  steep;
   logic [PROD_W-1:0]     prod;
   logic [REM_W-1:0]      rem_sh;
   logic                  rem_ge;

   // clamp geometry to the supported range
   always_comb begin
      if (row_length_ff == '0) begin
         eff_w = WID_W'(1);
      end else if (32'(row_length_ff) > 32'(MAX_ROW_LENGTH)) begin
         eff_w = WID_W'(MAX_ROW_LENGTH);
      end else begin
         eff_w = WID_W'(row_length_ff);
      end
      if (row_count_ff == '0) begin
         eff_h = ROW_CNT_W'(1);
      end else if (row_count_ff > ROW_CNT_W'(MAX_ROW_COUNT)) begin
         eff_h = ROW_CNT_W'(MAX_ROW_COUNT);
      end else begin
         eff_h = row_count_ff;
      end
   end

   assign data_phase   = row_ff < eff_h;
   assign emit_now     = (row_ff >= ROW_CNT_W'(2)) ||
                         ((row_ff == ROW_CNT_W'(1)) && (col_ff != '0));
   assign col_end      = WID_W'(col_ff) == (eff_w - WID_W'(1));
   assign ox_end       = WID_W'(ox_ff) == (eff_w - WID_W'(1));
   assign oz_end       = {1'b0, oz_ff} == (eff_h - ROW_CNT_W'(1));
   assign last_now     = ox_end && oz_end;
   assign interior_now = emit_now && (eff_w >= WID_W'(3)) && (eff_h >= ROW_CNT_W'(3)) &&
                         (ox_ff != '0) && !ox_end && (oz_ff != '0) && !oz_end;

   assign csr_take   = csr_ch.valid && csr_ch.ready;
   assign geom_write = csr_take && ((csr_ch.index == CSR_ROW_LENGTH) ||
                                    (csr_ch.index == CSR_ROW_COUNT));

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = cmd.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LENGTH_RESET;
         row_count_ff  <= ROW_COUNT_RESET;
         talus_ff      <= '0;
         gain_ff       <= '0;
      end else if (csr_take) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_ROW_LENGTH:  row_length_ff <= csr_ch.data[ROW_LEN_W-1:0];
            CSR_ROW_COUNT:   row_count_ff  <= csr_ch.data[ROW_CNT_W-1:0];
            CSR_TALUS_LIMIT: talus_ff      <= csr_ch.data;
            CSR_MOVE_GAIN:   gain_ff       <= csr_ch.data;
            default:         gain_ff       <= gain_ff;
         endcase
      end
   end

   // positions of the next input word and of the next result cell
   always_ff @(posedge clock) begin
      if (reset || geom_write) begin
         col_ff <= '0;
         row_ff <= '0;
         ox_ff  <= '0;
         oz_ff  <= '0;
      end else if (cmd.load) begin
         if (emit_now && last_now) begin
            col_ff <= '0;
            row_ff <= '0;
            ox_ff  <= '0;
            oz_ff  <= '0;
         end else begin
            if (col_end) begin
               col_ff <= '0;
               row_ff <= row_ff + ROW_CNT_W'(1);
            end else begin
               col_ff <= col_ff + COL_W'(1);
            end
            if (emit_now) begin
               if (ox_end) begin
                  ox_ff <= '0;
                  oz_ff <= oz_ff + OUT_ROW_W'(1);
               end else begin
                  ox_ff <= ox_ff + COL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= data_phase ? req_ch.height_in : '0;
      end
   end

   // line stores: read during idle, written on load at the same column
   always_ff @(posedge clock) begin
      rd_a_ff <= store_a_ff[col_ff];
      rd_b_ff <= store_b_ff[col_ff];
      if (cmd.load) begin
         store_a_ff[col_ff] <= sample_ff;
         store_b_ff[col_ff] <= rd_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_SIZE; i++) begin
            win_ff[i] <= '0;
         end
      end else if (cmd.load) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r*3]     <= win_ff[r*3 + 1];
            win_ff[r*3 + 1] <= win_ff[r*3 + 2];
         end
         win_ff[2] <= rd_b_ff;
         win_ff[5] <= rd_a_ff;
         win_ff[8] <= sample_ff;
      end
   end

   // one neighbor per scan step
   assign centre = win_ff[WIN_CENTRE];
   assign nb     = win_ff[nb_index(scan_idx_ff)];
   assign diff   = centre - nb;
   assign steep  = (centre > nb) && (diff > talus_ff);
   assign prod   = PROD_W'(sum_ff) * PROD_W'(gain_ff);
   assign rem_sh = {rem_ff[REM_W-2:0], dq_ff[QUOT_W-1]};
   assign rem_ge = rem_sh >= cnt_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         scan_idx_ff <= '0;
         sum_ff      <= '0;
         cnt_ff      <= '0;
         result_ff   <= win_ff[5];    // centre after the shift
         last_ff     <= last_now;
         interior_ff <= interior_now;
      end
      if (cmd.scan) begin
         scan_idx_ff <= scan_idx_ff + SCAN_IDX_W'(1);
         if (steep) begin
            sum_ff <= sum_ff + SUM_W'(diff - talus_ff);
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
      if (cmd.mult) begin
         dq_ff      <= prod[PROD_W-1:FRAC_SHIFT];
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end
      if (cmd.div) begin
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         if (rem_ge) begin
            rem_ff <= rem_sh - cnt_ff;
            dq_ff  <= {dq_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            dq_ff  <= {dq_ff[QUOT_W-2:0], 1'b0};
         end
      end
      if (cmd.fix) begin
         if (dq_ff > QUOT_W'(centre)) begin
            result_ff <= '0;
         end else begin
            result_ff <= centre - dq_ff[HEIGHT_W-1:0];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_height_ff <= result_ff;
         rsp_end_ff    <= last_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.height_out = rsp_height_ff;
   assign rsp_ch.map_end    = rsp_end_ff;

   always_comb begin
      status            = '0;
      status.req_valid  = req_ch.valid;
      status.drop       = data_phase && req_ch.req_type;
      status.emit       = emit_now;
      status.interior   = interior_now;
      status.scan_last  = scan_idx_ff == SCAN_LAST;
      status.count_zero = cnt_ff == '0;
      status.div_last   = div_cnt_ff == DIV_LAST;
      status.out_free   = !rsp_valid_ff || rsp_ch.ready;
      if (!interior_ff) begin
         status.count_zero = 1'b1;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/thermal_erosion_stencil.sv
// An edge cell passes from load straight to emit; an interior cell also takes 8 neighbor
// scan steps, a multiply, 17 divider steps and a fix step, skipping divide and fix when
// no neighbor lies below the talus. A stalled result word holds the sequencer in emit.
// A new word is taken only once the previous word is done, also when no cell is released;
// an early drain tick is taken while idle and is not loaded.
// Reset clears control, registers, counters and window; line stores keep old contents.
`default_nettype none

module thermal_erosion_stencil #(
   parameter int MAX_ROW_LENGTH = tes_pkg::DEF_MAX_ROW_LENGTH
) (
   input  wire        clock,
   input  wire        reset,
   tes_req_if.sink    req_ch,
   tes_rsp_if.source  rsp_ch,
   tes_csr_if.sink    csr_ch
);
   import tes_pkg::*;

   // Sequencer and datapath talk only through these two groups.
   cmd_type    cmd;
   status_type status;

   // Control: steps each loaded word through load, neighbor scan, multiply,
   // divide, fix and emit; holds the input side off until the word is done.
   tes_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // Datapath: line stores, 3x3 window, stream counters, erosion arithmetic and
   // the output register that lets a result word wait while the next word loads.
   tes_dpath #(
      .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch),
      .cmd    (cmd),
      .status (status)
   );

endmodule

`default_nettype wire

>>> hw/rtl/tes_checker.sv
// Port-level checks of the erosion stencil, attached to the top level by bind.
// Depends on tes_pkg for widths and on the top level's channel interfaces.
`default_nettype none

module tes_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [tes_pkg::HEIGHT_W-1:0]  height_out,
   input wire                          map_end
);
   import tes_pkg::*;

   // hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(height_out) && $stable(map_end))
      else $error("stalled result word changed");

   // a result needs at least the load cycle after its input word
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result word raised in the cycle after an input word");

   // reset leaves the block empty and ready for input
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty and ready after reset");

endmodule

bind thermal_erosion_stencil tes_checker u_tes_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .height_out (rsp_ch.height_out),
   .map_end    (rsp_ch.map_end)
);

`default_nettype wire
